// ----- src/lrk4_pkg.sv -----
// Package for the Lorenz RK4 integrator: word formats, register reset values,
// micro-operation codes and the step program. No dependencies.
`default_nettype none
package lrk4_pkg;

    localparam int WORD_BITS = 48;
    localparam int FRAC_BITS = 24;
    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int PROD_BITS = 2 * WORD_BITS;

    localparam logic [46:0] SIGMA_RST = 47'd167772160;
    localparam logic [46:0] RHO_RST   = 47'd469762048;
    localparam logic [46:0] BETA_RST  = 47'd44739243;
    localparam logic [24:0] DT_RST    = 25'd167772;
    localparam logic [47:0] START_RST = 48'd16777216;
    localparam logic [46:0] BOUND_RST = 47'd1677721600;

    localparam logic [2:0] REG_SIGMA = 3'd0;
    localparam logic [2:0] REG_RHO   = 3'd1;
    localparam logic [2:0] REG_BETA  = 3'd2;
    localparam logic [2:0] REG_DT    = 3'd3;
    localparam logic [2:0] REG_SX    = 3'd4;
    localparam logic [2:0] REG_SY    = 3'd5;
    localparam logic [2:0] REG_SZ    = 3'd6;
    localparam logic [2:0] REG_BOUND = 3'd7;

    // Reciprocal of six for step sizes below 2^27.
    localparam logic [25:0] DIV6_K     = 26'd44739243;
    localparam int          DIV6_SHIFT = 28;

    localparam int RAM_DEPTH = 16;
    localparam int RAM_AW    = 4;

    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL} t_op;

    // Operand codes: below 16 a scratch slot, 16 and above a fixed source.
    localparam logic [4:0] R_PX = 5'd0;
    localparam logic [4:0] R_PY = 5'd1;
    localparam logic [4:0] R_PZ = 5'd2;
    localparam logic [4:0] R_KX = 5'd3;
    localparam logic [4:0] R_KY = 5'd4;
    localparam logic [4:0] R_KZ = 5'd5;
    localparam logic [4:0] R_SX = 5'd6;
    localparam logic [4:0] R_SY = 5'd7;
    localparam logic [4:0] R_SZ = 5'd8;
    localparam logic [4:0] R_WX = 5'd9;
    localparam logic [4:0] R_WY = 5'd10;
    localparam logic [4:0] R_WZ = 5'd11;
    localparam logic [4:0] R_A  = 5'd12;
    localparam logic [4:0] R_B  = 5'd13;
    localparam logic [4:0] S_CX   = 5'd16;
    localparam logic [4:0] S_CY   = 5'd17;
    localparam logic [4:0] S_CZ   = 5'd18;
    localparam logic [4:0] S_SIG  = 5'd19;
    localparam logic [4:0] S_RHO  = 5'd20;
    localparam logic [4:0] S_BETA = 5'd21;
    localparam logic [4:0] S_DT   = 5'd22;
    localparam logic [4:0] S_HDT  = 5'd23;
    localparam logic [4:0] S_DT6  = 5'd24;
    localparam logic [4:0] S_ZERO = 5'd25;

    typedef struct packed {
        t_op        op;
        logic [4:0] sa;
        logic [4:0] sb;
        logic [4:0] dst;
    } t_uop;

    typedef struct packed {
        logic start;
        logic rd;
        t_uop uop;
        logic alu_wr;
        logic mul_go;
        logic mul_wr;
        logic check;
        logic restart;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
    } t_sts;

    localparam int NUM_UOPS = 77;
    localparam int PC_BITS  = 7;

    localparam t_uop UPROG [NUM_UOPS] = '{
        '{OP_ADD, S_CX, S_ZERO, R_PX}, '{OP_ADD, S_CY, S_ZERO, R_PY},
        '{OP_ADD, S_CZ, S_ZERO, R_PZ},
        '{OP_SUB, R_PY, R_PX, R_A}, '{OP_MUL, S_SIG, R_A, R_KX},
        '{OP_SUB, S_RHO, R_PZ, R_A}, '{OP_MUL, R_PX, R_A, R_A},
        '{OP_SUB, R_A, R_PY, R_KY}, '{OP_MUL, R_PX, R_PY, R_A},
        '{OP_MUL, S_BETA, R_PZ, R_B}, '{OP_SUB, R_A, R_B, R_KZ},
        '{OP_ADD, R_KX, S_ZERO, R_SX}, '{OP_ADD, R_KY, S_ZERO, R_SY},
        '{OP_ADD, R_KZ, S_ZERO, R_SZ},
        '{OP_MUL, S_HDT, R_KX, R_A}, '{OP_ADD, S_CX, R_A, R_PX},
        '{OP_MUL, S_HDT, R_KY, R_A}, '{OP_ADD, S_CY, R_A, R_PY},
        '{OP_MUL, S_HDT, R_KZ, R_A}, '{OP_ADD, S_CZ, R_A, R_PZ},
        '{OP_SUB, R_PY, R_PX, R_A}, '{OP_MUL, S_SIG, R_A, R_KX},
        '{OP_SUB, S_RHO, R_PZ, R_A}, '{OP_MUL, R_PX, R_A, R_A},
        '{OP_SUB, R_A, R_PY, R_KY}, '{OP_MUL, R_PX, R_PY, R_A},
        '{OP_MUL, S_BETA, R_PZ, R_B}, '{OP_SUB, R_A, R_B, R_KZ},
        '{OP_ADD, R_KX, R_KX, R_B}, '{OP_ADD, R_SX, R_B, R_SX},
        '{OP_ADD, R_KY, R_KY, R_B}, '{OP_ADD, R_SY, R_B, R_SY},
        '{OP_ADD, R_KZ, R_KZ, R_B}, '{OP_ADD, R_SZ, R_B, R_SZ},
        '{OP_MUL, S_HDT, R_KX, R_A}, '{OP_ADD, S_CX, R_A, R_PX},
        '{OP_MUL, S_HDT, R_KY, R_A}, '{OP_ADD, S_CY, R_A, R_PY},
        '{OP_MUL, S_HDT, R_KZ, R_A}, '{OP_ADD, S_CZ, R_A, R_PZ},
        '{OP_SUB, R_PY, R_PX, R_A}, '{OP_MUL, S_SIG, R_A, R_KX},
        '{OP_SUB, S_RHO, R_PZ, R_A}, '{OP_MUL, R_PX, R_A, R_A},
        '{OP_SUB, R_A, R_PY, R_KY}, '{OP_MUL, R_PX, R_PY, R_A},
        '{OP_MUL, S_BETA, R_PZ, R_B}, '{OP_SUB, R_A, R_B, R_KZ},
        '{OP_ADD, R_KX, R_KX, R_WX}, '{OP_ADD, R_KY, R_KY, R_WY},
        '{OP_ADD, R_KZ, R_KZ, R_WZ},
        '{OP_MUL, S_DT, R_KX, R_A}, '{OP_ADD, S_CX, R_A, R_PX},
        '{OP_MUL, S_DT, R_KY, R_A}, '{OP_ADD, S_CY, R_A, R_PY},
        '{OP_MUL, S_DT, R_KZ, R_A}, '{OP_ADD, S_CZ, R_A, R_PZ},
        '{OP_SUB, R_PY, R_PX, R_A}, '{OP_MUL, S_SIG, R_A, R_KX},
        '{OP_SUB, S_RHO, R_PZ, R_A}, '{OP_MUL, R_PX, R_A, R_A},
        '{OP_SUB, R_A, R_PY, R_KY}, '{OP_MUL, R_PX, R_PY, R_A},
        '{OP_MUL, S_BETA, R_PZ, R_B}, '{OP_SUB, R_A, R_B, R_KZ},
        '{OP_ADD, R_WX, R_KX, R_WX}, '{OP_ADD, R_SX, R_WX, R_SX},
        '{OP_MUL, S_DT6, R_SX, R_A}, '{OP_ADD, S_CX, R_A, S_CX},
        '{OP_ADD, R_WY, R_KY, R_WY}, '{OP_ADD, R_SY, R_WY, R_SY},
        '{OP_MUL, S_DT6, R_SY, R_A}, '{OP_ADD, S_CY, R_A, S_CY},
        '{OP_ADD, R_WZ, R_KZ, R_WZ}, '{OP_ADD, R_SZ, R_WZ, R_SZ},
        '{OP_MUL, S_DT6, R_SZ, R_A}, '{OP_ADD, S_CZ, R_A, S_CZ}
    };

    // Saturating sum or difference of two words.
    function automatic logic [WORD_BITS-1:0] sat_addsub(input logic [WORD_BITS-1:0] a,
                                                        input logic [WORD_BITS-1:0] b,
                                                        input logic sub);
        logic [WORD_BITS:0] s;
        s = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
                : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return s[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        return s[WORD_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- src/lrk4_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lrk4_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end
endmodule
`default_nettype wire

// ----- src/lrk4_mul.sv -----
// Fixed-point multiplier: four half-word partial products, accumulated in turn,
// then truncation and saturation. Depends on lrk4_pkg.
`default_nettype none
module lrk4_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_go,
    input  wire logic [lrk4_pkg::WORD_BITS-1:0] i_a,
    input  wire logic [lrk4_pkg::WORD_BITS-1:0] i_b,
    output logic                               o_done,
    output logic      [lrk4_pkg::WORD_BITS-1:0] o_prod
);
    localparam int W = lrk4_pkg::WORD_BITS;
    localparam int H = lrk4_pkg::HALF_BITS;
    localparam int P = lrk4_pkg::PROD_BITS;
    localparam int F = lrk4_pkg::FRAC_BITS;

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic [W-1:0] r_ma, r_mb;
    logic         r_neg;
    logic [W-1:0] r_pp;
    logic [1:0]   r_sh;
    logic [P-1:0] r_acc;
    logic [H-1:0] w_ah, w_bh;
    logic [P-1:0] w_pp_sh;
    logic [P-F-1:0] w_q;
    logic           w_over;

    assign w_ah = r_cnt[1] ? r_ma[W-1:H] : r_ma[H-1:0];
    assign w_bh = r_cnt[0] ? r_mb[W-1:H] : r_mb[H-1:0];

    always_comb begin
        case (r_sh)
            2'd0:    w_pp_sh = P'(r_pp);
            2'd3:    w_pp_sh = P'(r_pp) << (2 * H);
            default: w_pp_sh = P'(r_pp) << H;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= 3'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_ma  <= i_a[W-1] ? (~i_a + W'(1)) : i_a;
            r_mb  <= i_b[W-1] ? (~i_b + W'(1)) : i_b;
            r_neg <= i_a[W-1] ^ i_b[W-1];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt <= 3'd3) begin
                r_pp <= w_ah * w_bh;
                r_sh <= r_cnt[1:0];
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + w_pp_sh;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == 3'd5);
    assign w_q    = r_acc[P-1:F];
    assign w_over = |w_q[P-F-1:W-1];

    always_comb begin
        if (r_neg) begin
            o_prod = w_over ? {1'b1, {(W-1){1'b0}}} : (~w_q[W-1:0] + W'(1));
        end else begin
            o_prod = w_over ? {1'b0, {(W-1){1'b1}}} : w_q[W-1:0];
        end
    end
endmodule
`default_nettype wire

// ----- src/lrk4_dp.sv -----
// Datapath: configuration registers, point registers, scratch RAM, adder and
// multiplier, escape test and result registers. Depends on lrk4_pkg, lrk4_ram, lrk4_mul.
`default_nettype none
module lrk4_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [2:0]                    i_cfg_idx,
    input  wire logic [lrk4_pkg::WORD_BITS-1:0] i_cfg_data,
    input  wire lrk4_pkg::t_cmd                i_cmd,
    output lrk4_pkg::t_sts                     o_sts,
    output logic      [3*lrk4_pkg::WORD_BITS-1:0] o_data,
    output logic                               o_flag
);
    localparam int W = lrk4_pkg::WORD_BITS;

    logic [46:0] r_sigma, r_rho, r_beta, r_bound;
    logic [24:0] r_dt;
    logic [W-1:0] r_sx, r_sy, r_sz;
    logic [W-1:0] r_cx, r_cy, r_cz;
    logic [22:0]  r_dt6;
    logic [50:0]  w_dt6_prod;
    logic [W-1:0] w_ram_a, w_ram_b, w_opa, w_opb, w_alu, w_mul, w_wdata;
    logic         w_mul_done, w_esc, w_ram_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= lrk4_pkg::SIGMA_RST;
            r_rho   <= lrk4_pkg::RHO_RST;
            r_beta  <= lrk4_pkg::BETA_RST;
            r_dt    <= lrk4_pkg::DT_RST;
            r_sx    <= lrk4_pkg::START_RST;
            r_sy    <= lrk4_pkg::START_RST;
            r_sz    <= lrk4_pkg::START_RST;
            r_bound <= lrk4_pkg::BOUND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lrk4_pkg::REG_SIGMA: r_sigma <= i_cfg_data[46:0];
                lrk4_pkg::REG_RHO:   r_rho   <= i_cfg_data[46:0];
                lrk4_pkg::REG_BETA:  r_beta  <= i_cfg_data[46:0];
                lrk4_pkg::REG_DT:    r_dt    <= i_cfg_data[24:0];
                lrk4_pkg::REG_SX:    r_sx    <= i_cfg_data;
                lrk4_pkg::REG_SY:    r_sy    <= i_cfg_data;
                lrk4_pkg::REG_SZ:    r_sz    <= i_cfg_data;
                lrk4_pkg::REG_BOUND: r_bound <= i_cfg_data[46:0];
                default: ;
            endcase
        end
    end

    assign w_dt6_prod = 51'(r_dt) * 51'(lrk4_pkg::DIV6_K);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_dt6 <= w_dt6_prod[50:lrk4_pkg::DIV6_SHIFT];
        end
    end

    assign w_ram_we = (i_cmd.alu_wr || i_cmd.mul_wr) && !i_cmd.uop.dst[4];
    assign w_wdata  = i_cmd.mul_wr ? w_mul : w_alu;

    lrk4_ram #(.WIDTH(W), .DEPTH(lrk4_pkg::RAM_DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_ram_we),
        .i_waddr   (i_cmd.uop.dst[lrk4_pkg::RAM_AW-1:0]),
        .i_wdata   (w_wdata),
        .i_re      (i_cmd.rd),
        .i_raddr_a (i_cmd.uop.sa[lrk4_pkg::RAM_AW-1:0]),
        .i_raddr_b (i_cmd.uop.sb[lrk4_pkg::RAM_AW-1:0]),
        .o_rdata_a (w_ram_a),
        .o_rdata_b (w_ram_b)
    );

    function automatic logic [W-1:0] pick(input logic [4:0] code, input logic [W-1:0] ram);
        case (code)
            lrk4_pkg::S_CX:   return r_cx;
            lrk4_pkg::S_CY:   return r_cy;
            lrk4_pkg::S_CZ:   return r_cz;
            lrk4_pkg::S_SIG:  return W'(r_sigma);
            lrk4_pkg::S_RHO:  return W'(r_rho);
            lrk4_pkg::S_BETA: return W'(r_beta);
            lrk4_pkg::S_DT:   return W'(r_dt);
            lrk4_pkg::S_HDT:  return W'(r_dt[24:1]);
            lrk4_pkg::S_DT6:  return W'(r_dt6);
            lrk4_pkg::S_ZERO: return '0;
            default:          return ram;
        endcase
    endfunction

    assign w_opa = pick(i_cmd.uop.sa, w_ram_a);
    assign w_opb = pick(i_cmd.uop.sb, w_ram_b);
    assign w_alu = lrk4_pkg::sat_addsub(w_opa, w_opb, i_cmd.uop.op == lrk4_pkg::OP_SUB);

    lrk4_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (w_opa),
        .i_b     (w_opb),
        .o_done  (w_mul_done),
        .o_prod  (w_mul)
    );

    assign o_sts.mul_done = w_mul_done;

    function automatic logic beyond(input logic [W-1:0] v, input logic [46:0] lim);
        logic [W-1:0] m;
        m = v[W-1] ? (~v + W'(1)) : v;
        return m > W'(lim);
    endfunction

    assign w_esc = beyond(r_cx, r_bound) || beyond(r_cy, r_bound) || beyond(r_cz, r_bound);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= lrk4_pkg::START_RST;
            r_cy <= lrk4_pkg::START_RST;
            r_cz <= lrk4_pkg::START_RST;
        end else if (i_cmd.check) begin
            if (i_cmd.restart || w_esc) begin
                r_cx <= r_sx;
                r_cy <= r_sy;
                r_cz <= r_sz;
            end
        end else if ((i_cmd.alu_wr || i_cmd.mul_wr) && i_cmd.uop.dst[4]) begin
            case (i_cmd.uop.dst)
                lrk4_pkg::S_CX: r_cx <= w_wdata;
                lrk4_pkg::S_CY: r_cy <= w_wdata;
                lrk4_pkg::S_CZ: r_cz <= w_wdata;
                default: ;
            endcase
        end
    end

    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_hit <= i_cmd.restart || w_esc;
        end
        if (i_cmd.out_load) begin
            o_data <= {r_cz, r_cy, r_cx};
            o_flag <= r_hit;
        end
    end
endmodule
`default_nettype wire

// ----- src/lrk4_ctrl.sv -----
// Controller: input and output handshakes and the sequencer that walks the
// step program. Depends on lrk4_pkg.
`default_nettype none
module lrk4_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_restart,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire lrk4_pkg::t_sts i_sts,
    output lrk4_pkg::t_cmd     o_cmd
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FETCH = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_MULW  = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [lrk4_pkg::PC_BITS-1:0] r_pc, n_pc;
    logic r_restart, n_restart, r_vld, n_vld;
    lrk4_pkg::t_uop w_uop;
    logic w_last;

    assign w_uop  = lrk4_pkg::UPROG[r_pc];
    assign w_last = (r_pc == lrk4_pkg::PC_BITS'(lrk4_pkg::NUM_UOPS - 1));
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_vld;

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_restart = r_restart;
        n_vld     = r_vld && !i_out_ready;
        o_cmd     = '0;
        o_cmd.uop = w_uop;
        o_cmd.restart = r_restart;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_restart = i_in_restart;
                    n_pc      = '0;
                    if (i_in_restart) begin
                        n_state = ST_CHECK;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EXEC;
            end
            ST_EXEC: begin
                if (w_uop.op == lrk4_pkg::OP_MUL) begin
                    o_cmd.mul_go = 1'b1;
                    n_state      = ST_MULW;
                end else begin
                    o_cmd.alu_wr = 1'b1;
                    n_pc    = r_pc + 1'b1;
                    n_state = w_last ? ST_CHECK : ST_FETCH;
                end
            end
            ST_MULW: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_wr = 1'b1;
                    n_pc    = r_pc + 1'b1;
                    n_state = w_last ? ST_CHECK : ST_FETCH;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (!r_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_vld          = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pc      <= '0;
            r_restart <= 1'b0;
            r_vld     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_restart <= n_restart;
            r_vld     <= n_vld;
        end
    end
endmodule
`default_nettype wire

// ----- src/lorenz_rk4_integrator_unit.sv -----
// Top level of the Lorenz RK4 integrator: controller and datapath.
// Depends on lrk4_pkg, lrk4_ctrl, lrk4_dp.
//
//   channel   direction  payload
//   s_axis    in         tdata[0] restart
//   m_axis    out        tdata pos_x, pos_y, pos_z; tuser was_restarted
//   i_cfg     in         index 0..7, data up to 48 bits
//
// A step runs 77 micro-operations, 49 adder operations and 28 multiplications through
// the shared half-word multiplier, plus the accept, check and output steps; a restart
// request runs only the check and output steps. A new request is taken only once the
// last one has reached the output register. Reset is synchronous and active low.
// A finished result waits in the output register while the next request is taken.
`default_nettype none
module lorenz_rk4_integrator_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [0] restart
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [143:0] m_axis_tdata,   // [47:0] pos_x, [95:48] pos_y, [143:96] pos_z
    output logic      [0:0]   m_axis_tuser,   // [0] was_restarted
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [47:0]  i_cfg_data
);
    lrk4_pkg::t_cmd w_cmd;
    lrk4_pkg::t_sts w_sts;
    logic           w_flag;

    lrk4_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_restart (s_axis_tdata[0]),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    lrk4_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_data     (m_axis_tdata),
        .o_flag     (w_flag)
    );

    assign m_axis_tuser[0] = w_flag;

`ifndef SYNTHESIS
    a_mul_not_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mul_go |=> !w_sts.mul_done)
        else $error("multiplier finished in the cycle after it started");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> m_axis_tvalid)
        else $error("result loaded without raising valid");
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while a step was starting");
`endif
endmodule
`default_nettype wire

// ----- test/tb_lorenz_rk4_integrator_unit.sv -----
// Self-checking testbench for lorenz_rk4_integrator_unit: drives step and restart
// requests, predicts each RK4 step in fixed point and checks every result.
// Depends on lrk4_pkg and the integrator RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_lorenz_rk4_integrator_unit;
    import lrk4_pkg::*;

    localparam longint WMAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
    localparam longint WMIN = -WMAX - 1;
    localparam longint CYCLE_LIMIT = 6000000;

    typedef struct {
        logic [47:0] px;
        logic [47:0] py;
        logic [47:0] pz;
        logic        flag;
    } t_point;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_idx;
    logic [47:0]  i_cfg_data;

    lorenz_rk4_integrator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    logic [47:0] coef [8];
    longint      pt_x, pt_y, pt_z;
    t_point      expected_points [$];
    int          mismatches;
    int          results_seen;
    int          requests_sent;
    int          restarts_seen;
    longint      cycles = 0;
    bit          calm;
    bit          hold_req;
    bit          hold_taken;
    int          hold_cnt;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("tb_lorenz_rk4_integrator_unit NOT OK");
            $finish;
        end
    end

    // Fixed-point arithmetic of the block.
    function automatic longint clamp_word(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint sat_add(longint a, longint b);
        return clamp_word(a + b);
    endfunction

    function automatic longint sat_sub(longint a, longint b);
        return clamp_word(a - b);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        logic [63:0]  ma, mb;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        p = (128'(ma) * 128'(mb)) >> FRAC_BITS;
        if (neg) begin
            if (p > (128'(1) << (WORD_BITS - 1))) return WMIN;
            return -longint'(p[63:0]);
        end
        if (p > 128'(WMAX)) return WMAX;
        return longint'(p[63:0]);
    endfunction

    function automatic longint coef_u(logic [2:0] idx);
        return longint'({16'b0, coef[idx]});
    endfunction

    function automatic longint coef_s(logic [2:0] idx);
        longint v;
        v = $signed(coef[idx]);
        return v;
    endfunction

    task automatic lorenz_slope(input longint x, y, z, output longint dx, dy, dz);
        dx = fx_mul(coef_u(REG_SIGMA), sat_sub(y, x));
        dy = sat_sub(fx_mul(x, sat_sub(coef_u(REG_RHO), z)), y);
        dz = sat_sub(fx_mul(x, y), fx_mul(coef_u(REG_BETA), z));
    endtask

    function automatic longint magn(longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic advance_point(input bit restart);
        longint dt, hdt, dt6, bnd;
        longint k1x, k1y, k1z, k2x, k2y, k2z, k3x, k3y, k3z, k4x, k4y, k4z;
        longint x, y, z;
        bit     flag;
        t_point r;
        flag = restart;
        if (!restart) begin
            dt = coef_u(REG_DT);
            hdt = dt >>> 1;
            dt6 = dt / 6;
            bnd = coef_u(REG_BOUND);
            x = pt_x; y = pt_y; z = pt_z;
            lorenz_slope(x, y, z, k1x, k1y, k1z);
            lorenz_slope(sat_add(x, fx_mul(hdt, k1x)), sat_add(y, fx_mul(hdt, k1y)),
                         sat_add(z, fx_mul(hdt, k1z)), k2x, k2y, k2z);
            lorenz_slope(sat_add(x, fx_mul(hdt, k2x)), sat_add(y, fx_mul(hdt, k2y)),
                         sat_add(z, fx_mul(hdt, k2z)), k3x, k3y, k3z);
            lorenz_slope(sat_add(x, fx_mul(dt, k3x)), sat_add(y, fx_mul(dt, k3y)),
                         sat_add(z, fx_mul(dt, k3z)), k4x, k4y, k4z);
            x = sat_add(x, fx_mul(dt6, sat_add(sat_add(k1x, sat_add(k2x, k2x)),
                                               sat_add(sat_add(k3x, k3x), k4x))));
            y = sat_add(y, fx_mul(dt6, sat_add(sat_add(k1y, sat_add(k2y, k2y)),
                                               sat_add(sat_add(k3y, k3y), k4y))));
            z = sat_add(z, fx_mul(dt6, sat_add(sat_add(k1z, sat_add(k2z, k2z)),
                                               sat_add(sat_add(k3z, k3z), k4z))));
            pt_x = x; pt_y = y; pt_z = z;
            if (magn(x) > bnd || magn(y) > bnd || magn(z) > bnd) flag = 1'b1;
        end
        if (flag) begin
            pt_x = coef_s(REG_SX);
            pt_y = coef_s(REG_SY);
            pt_z = coef_s(REG_SZ);
        end
        r.px = pt_x[47:0];
        r.py = pt_y[47:0];
        r.pz = pt_z[47:0];
        r.flag = flag;
        expected_points.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [47:0] got, exp);
        mismatches++;
        if (mismatches <= 40)
            $display("Mismatch in %s at result %0d: got %h, expected %h.",
                     what, results_seen, got, exp);
    endtask

    // Receiver: random stalls unless calm, plus a long hold-off when asked for.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_cnt <= 0;
            hold_taken <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cnt <= 2500;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[47:0], 48'h0);
            end else begin
                e = expected_points.pop_front();
                if (m_axis_tdata[47:0] !== e.px)
                    report_mismatch("pos_x", m_axis_tdata[47:0], e.px);
                if (m_axis_tdata[95:48] !== e.py)
                    report_mismatch("pos_y", m_axis_tdata[95:48], e.py);
                if (m_axis_tdata[143:96] !== e.pz)
                    report_mismatch("pos_z", m_axis_tdata[143:96], e.pz);
                if (m_axis_tuser[0] !== e.flag)
                    report_mismatch("was_restarted", 48'(m_axis_tuser[0]), 48'(e.flag));
                if (e.flag) restarts_seen++;
            end
            results_seen++;
        end
    end

    task automatic send_request(input bit restart);
        while (!calm && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_point(restart);
        requests_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_points.size() != 0 || m_axis_tvalid) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_coef(input logic [2:0] idx, input logic [47:0] val);
        logic [47:0] mask;
        case (idx)
            REG_DT: begin
                mask = 48'h1FF_FFFF;
            end
            REG_SX, REG_SY, REG_SZ: begin
                mask = '1;
            end
            default: begin
                mask = 48'h7FFF_FFFF_FFFF;
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        coef[idx] = val & mask;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] rand_word;
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [47:0] rand_signed_q(int whole);
        longint v;
        v = (longint'($urandom_range(2 * whole)) - whole) <<< FRAC_BITS;
        v = v + $urandom_range(24'hFF_FFFF);
        return v[47:0];
    endfunction

    task automatic plausible_settings;
        write_coef(REG_SIGMA, 48'($urandom_range(4, 16)) << FRAC_BITS | $urandom_range(24'hFFFFFF));
        write_coef(REG_RHO, 48'($urandom_range(10, 45)) << FRAC_BITS | $urandom_range(24'hFFFFFF));
        write_coef(REG_BETA, 48'($urandom_range(1, 4)) << FRAC_BITS | $urandom_range(24'hFFFFFF));
        write_coef(REG_DT, 48'($urandom_range(1000, 400000)));
        write_coef(REG_SX, rand_signed_q(20));
        write_coef(REG_SY, rand_signed_q(20));
        write_coef(REG_SZ, rand_signed_q(40));
        write_coef(REG_BOUND, 48'($urandom_range(25, 150)) << FRAC_BITS);
    endtask

    task automatic wild_settings;
        for (int i = 0; i < 8; i++) write_coef(3'(i), rand_word());
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) send_request($urandom_range(99) < 6);
    endtask

    task automatic test_reset_defaults;
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain();
    endtask

    task automatic test_escape;
        write_coef(REG_BOUND, 48'h0);
        send_request(1'b0);
        send_request(1'b0);
        drain();
        write_coef(REG_BOUND, 48'h7FFF_FFFF_FFFF);
        write_coef(REG_SX, 48'h0);
        write_coef(REG_SY, 48'h0);
        write_coef(REG_SZ, 48'h0);
        send_request(1'b1);
        send_request(1'b0);
        drain();
    endtask

    task automatic test_extremes;
        write_coef(REG_SX, 48'h7FFF_FFFF_FFFF);
        write_coef(REG_SY, 48'h8000_0000_0000);
        write_coef(REG_SZ, 48'h7FFF_FFFF_FFFF);
        write_coef(REG_SIGMA, 48'h7FFF_FFFF_FFFF);
        write_coef(REG_RHO, 48'h7FFF_FFFF_FFFF);
        write_coef(REG_BETA, 48'h7FFF_FFFF_FFFF);
        write_coef(REG_DT, 48'h100_0000);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        drain();
        write_coef(REG_DT, 48'h0);
        write_coef(REG_SIGMA, 48'h0);
        write_coef(REG_RHO, 48'h0);
        write_coef(REG_BETA, 48'h0);
        write_coef(REG_SY, 48'h8000_0000_0000);
        send_request(1'b1);
        send_request(1'b0);
        drain();
        write_coef(REG_DT, 48'hFFFF_FFFF_FFFF);
        send_request(1'b0);
        send_request(1'b0);
        drain();
    endtask

    task automatic test_backpressure;
        calm = 1'b1;
        hold_req = 1'b1;
        run_random(20);
        calm = 1'b0;
        drain();
        run_random(10);
        drain();
        run_random(10);
        drain();
    endtask

    task automatic test_random_settings;
        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 3 || phase == 8) wild_settings();
            else plausible_settings();
            calm = (phase == 5);
            run_random(phase == 3 || phase == 8 ? 40 : 180);
            calm = 1'b0;
            drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        hold_req = 1'b0;
        calm = 1'b0;
        mismatches = 0;
        results_seen = 0;
        requests_sent = 0;
        restarts_seen = 0;
        coef[REG_SIGMA] = {1'b0, SIGMA_RST};
        coef[REG_RHO] = {1'b0, RHO_RST};
        coef[REG_BETA] = {1'b0, BETA_RST};
        coef[REG_DT] = {23'b0, DT_RST};
        coef[REG_SX] = START_RST;
        coef[REG_SY] = START_RST;
        coef[REG_SZ] = START_RST;
        coef[REG_BOUND] = {1'b0, BOUND_RST};
        pt_x = coef_s(REG_SX);
        pt_y = coef_s(REG_SY);
        pt_z = coef_s(REG_SZ);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_escape();
        test_extremes();
        test_backpressure();
        test_random_settings();

        drain();
        repeat (300) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived.", expected_points.size());
        end
        $display("Sent %0d step and restart requests over many coefficient settings,",
                 requests_sent);
        $display("checked %0d results, %0d of them reloads from the start point.",
                 results_seen, restarts_seen);
        if (mismatches == 0) begin
            $display("tb_lorenz_rk4_integrator_unit OK");
        end else begin
            $display("tb_lorenz_rk4_integrator_unit NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
src/lrk4_pkg.sv
src/lrk4_ram.sv
src/lrk4_mul.sv
src/lrk4_dp.sv
src/lrk4_ctrl.sv
src/lorenz_rk4_integrator_unit.sv
test/tb_lorenz_rk4_integrator_unit.sv
